/* hdl/poe_power_monitor_assert.svh */
// ----------------------------------------------------------------------------
// poe power monitor assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef POE_POWER_MONITOR_ASSERT_SVH
`define POE_POWER_MONITOR_ASSERT_SVH

// same-cycle implication
`define PPM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("poe_power_monitor: same-cycle check failed");

// next-cycle implication
`define PPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("poe_power_monitor: next-cycle check failed");

`endif

/* hdl/ppm_pkg.sv */
// ----------------------------------------------------------------------------
// ppm_pkg
// Types and constants shared by the power monitor modules.
// ----------------------------------------------------------------------------
package ppm_pkg;

  localparam int DEBOUNCE_COUNT_DEF = 5;
  localparam int SAMPLE_WIDTH_DEF   = 16;

  localparam int MV_W     = 16;  // register and median width
  localparam int BUDGET_W = 12;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [MV_W-1:0] VBUS_MIN_RST  = 16'd36000;
  localparam logic [MV_W-1:0] VBUS_HYST_RST = 16'd1000;

  localparam logic [BUDGET_W-1:0] BUDGET_NONE_CW  = 12'd0;
  localparam logic [BUDGET_W-1:0] BUDGET_TYPE1_CW = 12'd1295;
  localparam logic [BUDGET_W-1:0] BUDGET_TYPE2_CW = 12'd2550;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_TYPE1 = 2'd1,
    CLS_TYPE2 = 2'd2
  } ppm_class_e;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_VBUS_MIN  = 1'b0,
    REG_VBUS_HYST = 1'b1
  } ppm_reg_e;

  // debouncer status: confirmed value after this item and before it
  typedef struct packed {
    logic value;
    logic prev;
  } ppm_deb_t;

endpackage

/* hdl/ppm_in_if.sv */
// ----------------------------------------------------------------------------
// ppm_in_if
// Sample tick channel: raw pins and three bus readings with read-ok flags.
// ----------------------------------------------------------------------------
interface ppm_in_if #(
  parameter int SAMPLE_WIDTH = ppm_pkg::SAMPLE_WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic                    cdb_level;
  logic                    t2p_level;
  logic [SAMPLE_WIDTH-1:0] vbus_a;
  logic [SAMPLE_WIDTH-1:0] vbus_b;
  logic [SAMPLE_WIDTH-1:0] vbus_c;
  logic                    a_valid;
  logic                    b_valid;
  logic                    c_valid;

  modport source (
    output valid, cdb_level, t2p_level, vbus_a, vbus_b, vbus_c, a_valid, b_valid, c_valid,
    input  ready
  );
  modport sink (
    input  valid, cdb_level, t2p_level, vbus_a, vbus_b, vbus_c, a_valid, b_valid, c_valid,
    output ready
  );
endinterface

/* hdl/ppm_out_if.sv */
// ----------------------------------------------------------------------------
// ppm_out_if
// Status channel: debounced flags, class, budget and change events.
// ----------------------------------------------------------------------------
interface ppm_out_if;
  import ppm_pkg::*;

  logic                valid;
  logic                ready;
  logic                ready_res;
  logic [1:0]          source_class;
  logic                inrush_done_ok;
  logic                type2_ok;
  logic [MV_W-1:0]     vbus_median;
  logic                ready_rise;
  logic                ready_fall;
  logic                class_changed;
  logic                inrush_changed;
  logic                type2_changed;
  logic [BUDGET_W-1:0] budget_cw;

  modport source (
    output valid, ready_res, source_class, inrush_done_ok, type2_ok, vbus_median,
           ready_rise, ready_fall, class_changed, inrush_changed, type2_changed, budget_cw,
    input  ready
  );
  modport sink (
    input  valid, ready_res, source_class, inrush_done_ok, type2_ok, vbus_median,
           ready_rise, ready_fall, class_changed, inrush_changed, type2_changed, budget_cw,
    output ready
  );
endinterface

/* hdl/poe_power_monitor.sv */
// ----------------------------------------------------------------------------
// poe_power_monitor
// Debounced, hysteretic power-source monitor with class and budget report.
// ----------------------------------------------------------------------------
// Usage: each item on item_in is one sample tick carrying the power-good pin,
// the active-low class pin and three bus readings with read-ok flags. Each
// item yields exactly one status item on item_out: the median reading, the
// debounced ready, power-good and class flags, the source class, the power
// budget and edge events.
// Acceptance reaches a valid status item through the input register, then
// the result register; one item is taken every cycle while item_out is not
// stalled. The debouncer and class state advances as an item moves into the
// result register.
// A stall on item_out holds the result register and then the input register;
// item_in.ready drops only when both are full.
// After reset the thresholds are 36000 mV and 1000 mV of hysteresis, and the
// first item only primes the debouncers: its status carries the median and
// zeros elsewhere. Thresholds are written over the APB port at 0x0 and 0x4;
// the user must write them while no item is in flight; the block has no check.
// ----------------------------------------------------------------------------
`include "poe_power_monitor_assert.svh"

module poe_power_monitor #(
  parameter int DEBOUNCE_COUNT = ppm_pkg::DEBOUNCE_COUNT_DEF,
  parameter int SAMPLE_WIDTH   = ppm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ppm_in_if.sink                      item_in,
  ppm_out_if.source                   item_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppm_pkg::APB_AW-1:0]  paddr,
  input  logic [ppm_pkg::APB_DW-1:0]  pwdata,
  output logic [ppm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import ppm_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int CW = ((SW > MV_W) ? SW : MV_W) + 2;  // signed compare width

  // ---------------- configuration ----------------
  logic [MV_W-1:0] vbus_min_q, vbus_hyst_q;
  ppm_reg_e        reg_sel;
  logic            cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = ppm_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbus_min_q  <= VBUS_MIN_RST;
      vbus_hyst_q <= VBUS_HYST_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_VBUS_MIN:  vbus_min_q  <= pwdata[MV_W-1:0];
        REG_VBUS_HYST: vbus_hyst_q <= pwdata[MV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_VBUS_MIN:  prdata = APB_DW'(vbus_min_q);
      REG_VBUS_HYST: prdata = APB_DW'(vbus_hyst_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  logic          s1_valid_q;
  logic          s1_cdb_q, s1_t2p_q;
  logic [SW-1:0] s1_a_q, s1_b_q, s1_c_q;
  logic          out_can, s1_fire;

  assign out_can       = !item_out.valid || item_out.ready;
  assign s1_fire       = s1_valid_q && out_can;
  assign item_in.ready = !s1_valid_q || out_can;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (item_in.ready) begin
      s1_valid_q <= item_in.valid;
    end
  end

  // failed readings count as zero
  always_ff @(posedge clk_i) begin
    if (item_in.ready && item_in.valid) begin
      s1_cdb_q <= item_in.cdb_level;
      s1_t2p_q <= item_in.t2p_level;
      s1_a_q   <= item_in.a_valid ? item_in.vbus_a : '0;
      s1_b_q   <= item_in.b_valid ? item_in.vbus_b : '0;
      s1_c_q   <= item_in.c_valid ? item_in.vbus_c : '0;
    end
  end

  // ---------------- evaluation ----------------
  logic          primed_q;
  ppm_class_e    prev_class_q;
  logic [SW-1:0] mn_ab, mx_ab, mid_hi, med;
  logic [CW-1:0] med_x;
  logic [CW-1:0] thr;
  logic          ok_raw;
  ppm_deb_t      cdb_st, t2p_st, ok_st;
  ppm_class_e    cls;
  logic [BUDGET_W-1:0] budget;

  assign mn_ab  = (s1_a_q < s1_b_q) ? s1_a_q : s1_b_q;
  assign mx_ab  = (s1_a_q < s1_b_q) ? s1_b_q : s1_a_q;
  assign mid_hi = (mx_ab < s1_c_q) ? mx_ab : s1_c_q;
  assign med    = (mn_ab > mid_hi) ? mn_ab : mid_hi;
  assign med_x  = CW'(med);

  // threshold drops by the hysteresis while the bus is confirmed ok
  assign thr    = CW'(vbus_min_q) - (ok_st.prev ? CW'(vbus_hyst_q) : '0);
  assign ok_raw = $signed(med_x) >= $signed(thr);

  ppm_debounce #(.DEBOUNCE_COUNT(DEBOUNCE_COUNT)) u_deb_cdb (
    .clk_i, .rst_ni, .step_i(s1_fire), .prime_i(!primed_q),
    .sample_i(s1_cdb_q), .status_o(cdb_st)
  );

  ppm_debounce #(.DEBOUNCE_COUNT(DEBOUNCE_COUNT)) u_deb_t2p (
    .clk_i, .rst_ni, .step_i(s1_fire), .prime_i(!primed_q),
    .sample_i(!s1_t2p_q), .status_o(t2p_st)
  );

  ppm_debounce #(.DEBOUNCE_COUNT(DEBOUNCE_COUNT)) u_deb_ok (
    .clk_i, .rst_ni, .step_i(s1_fire), .prime_i(!primed_q),
    .sample_i(ok_raw), .status_o(ok_st)
  );

  always_comb begin
    if (!ok_st.value) begin
      cls = CLS_NONE;
    end else if (t2p_st.value) begin
      cls = CLS_TYPE2;
    end else begin
      cls = CLS_TYPE1;
    end
    case (cls)
      CLS_TYPE1: budget = BUDGET_TYPE1_CW;
      CLS_TYPE2: budget = BUDGET_TYPE2_CW;
      default:   budget = BUDGET_NONE_CW;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q     <= 1'b0;
      prev_class_q <= CLS_NONE;
    end else if (s1_fire) begin
      primed_q <= 1'b1;
      if (primed_q) begin
        prev_class_q <= cls;
      end
    end
  end

  // ---------------- result register ----------------
  logic                out_valid_q;
  logic                res_ready_q, res_inrush_q, res_type2_q;
  logic [1:0]          res_class_q;
  logic [MV_W-1:0]     res_median_q;
  logic                res_rise_q, res_fall_q, res_cls_chg_q, res_inr_chg_q, res_t2_chg_q;
  logic [BUDGET_W-1:0] res_budget_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_can) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_median_q <= med_x[MV_W-1:0];
      if (primed_q) begin
        res_ready_q   <= ok_st.value;
        res_class_q   <= cls;
        res_inrush_q  <= cdb_st.value;
        res_type2_q   <= t2p_st.value;
        res_rise_q    <= ok_st.value && !ok_st.prev;
        res_fall_q    <= !ok_st.value && ok_st.prev;
        res_cls_chg_q <= cls != prev_class_q;
        res_inr_chg_q <= cdb_st.value != cdb_st.prev;
        res_t2_chg_q  <= t2p_st.value != t2p_st.prev;
        res_budget_q  <= budget;
      end else begin
        // priming item reports the median only
        res_ready_q   <= 1'b0;
        res_class_q   <= CLS_NONE;
        res_inrush_q  <= 1'b0;
        res_type2_q   <= 1'b0;
        res_rise_q    <= 1'b0;
        res_fall_q    <= 1'b0;
        res_cls_chg_q <= 1'b0;
        res_inr_chg_q <= 1'b0;
        res_t2_chg_q  <= 1'b0;
        res_budget_q  <= BUDGET_NONE_CW;
      end
    end
  end

  assign item_out.valid          = out_valid_q;
  assign item_out.ready_res      = res_ready_q;
  assign item_out.source_class   = res_class_q;
  assign item_out.inrush_done_ok = res_inrush_q;
  assign item_out.type2_ok       = res_type2_q;
  assign item_out.vbus_median    = res_median_q;
  assign item_out.ready_rise     = res_rise_q;
  assign item_out.ready_fall     = res_fall_q;
  assign item_out.class_changed  = res_cls_chg_q;
  assign item_out.inrush_changed = res_inr_chg_q;
  assign item_out.type2_changed  = res_t2_chg_q;
  assign item_out.budget_cw      = res_budget_q;

  // ---------------- assertions ----------------
  `PPM_ASSERT_NOW(a_budget_class, out_valid_q, (res_budget_q == BUDGET_NONE_CW) == (res_class_q == CLS_NONE))
  `PPM_ASSERT_NEXT(a_prime_quiet, s1_fire && !primed_q, !res_ready_q && !res_rise_q && !res_cls_chg_q)
  `PPM_ASSERT_NEXT(a_stall_holds, s1_valid_q && !out_can, s1_valid_q && out_valid_q)

endmodule

/* hdl/ppm_debounce.sv */
// ----------------------------------------------------------------------------
// ppm_debounce
// Counting debouncer: a new level is confirmed once DEBOUNCE_COUNT samples in
// a row repeat the one that began the run; the run count saturates there.
// ----------------------------------------------------------------------------
module ppm_debounce #(
  parameter int DEBOUNCE_COUNT = ppm_pkg::DEBOUNCE_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              prime_i,
  input  logic              sample_i,
  output ppm_pkg::ppm_deb_t status_o
);
  import ppm_pkg::*;

  localparam int              CNT_W  = $clog2(DEBOUNCE_COUNT + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEBOUNCE_COUNT);

  logic             last_q, last_d;
  logic             conf_q, conf_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    last_d = last_q;
    cnt_d  = cnt_q;
    conf_d = conf_q;
    if (prime_i) begin
      // first item after reset only loads the sample
      last_d = sample_i;
    end else begin
      if (sample_i == last_q) begin
        if (cnt_q < CNT_MAX) begin
          cnt_d = cnt_q + 1'b1;
        end
      end else begin
        cnt_d  = '0;
        last_d = sample_i;
      end
      if (cnt_d >= CNT_MAX) begin
        conf_d = sample_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
      conf_q <= 1'b0;
      cnt_q  <= '0;
    end else if (step_i) begin
      last_q <= last_d;
      conf_q <= conf_d;
      cnt_q  <= cnt_d;
    end
  end

  assign status_o.value = conf_d;
  assign status_o.prev  = conf_q;

endmodule
